// ===== design/sgacc_pkg.sv =====
// ----------------------------------------------------------------------------
// sgacc_pkg
// Shared types and constants of the softened gravity accumulator.
// ----------------------------------------------------------------------------
package sgacc_pkg;

    localparam int ValW   = 32;   // Q16.16 input words
    localparam int SumW   = 64;   // Q32.32 sums
    localparam int MagW   = 63;   // saturated quotient magnitude
    localparam int RwW    = 68;   // |d|^2 + softening, exact
    localparam int RootW  = 34;   // floor(sqrt(rw))
    localparam int ProdW  = 128;  // full multiplier product
    localparam int NumW   = 128;  // divider numerator
    localparam int DenW   = 64;   // divider denominator
    localparam int CfgIdxW = 3;
    localparam int QDepth = 2;    // front to back term queue
    localparam int QPtrW  = 1;

    localparam logic [CfgIdxW-1:0] CFG_TARGET_X  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_TARGET_Y  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_TARGET_Z  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SOFTENING = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_USE_QUAD  = 3'd4;

    localparam logic [MagW-1:0] MagMax = {MagW{1'b1}};

    // classified source term, as handed from front to back
    typedef struct packed {
        logic [2:0][ValW-1:0] ax;    // |src - target| per axis
        logic [2:0]           neg;   // src - target < 0
        logic [ValW-1:0]      mass;
        logic [5:0][ValW-1:0] q;     // xx xy xz yy yz zz, two's complement
        logic                 quad;  // cell with quadrupoles enabled
        logic                 last;
    } t_term;

    typedef struct packed {
        logic [SumW-1:0] acc_x;
        logic [SumW-1:0] acc_y;
        logic [SumW-1:0] acc_z;
        logic [SumW-1:0] pot;
    } t_result;

endpackage

// ===== design/sgacc_front.sv =====
// ----------------------------------------------------------------------------
// sgacc_front
// Accepts source words, forms separation magnitudes and signs, queues terms.
// ----------------------------------------------------------------------------
module sgacc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [31:0]            i_src_x,
    input  logic signed [31:0]            i_src_y,
    input  logic signed [31:0]            i_src_z,
    input  logic [31:0]                   i_src_mass,
    input  logic signed [31:0]            i_q_xx,
    input  logic signed [31:0]            i_q_xy,
    input  logic signed [31:0]            i_q_xz,
    input  logic signed [31:0]            i_q_yy,
    input  logic signed [31:0]            i_q_yz,
    input  logic signed [31:0]            i_q_zz,
    input  logic                          i_is_cell,
    input  logic                          i_last_term,
    input  logic signed [31:0]            i_target_x,
    input  logic signed [31:0]            i_target_y,
    input  logic signed [31:0]            i_target_z,
    input  logic                          i_use_quad,
    output logic                          o_term_valid,
    output sgacc_pkg::t_term              o_term,
    input  logic                          i_term_take
);
    import sgacc_pkg::*;

    t_term              r_mem [QDepth];
    logic [QPtrW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QPtrW:0]     r_count;
    t_term              w_term;
    logic signed [32:0] w_d [3];
    logic               w_wr;

    always_comb begin
        w_d[0] = {i_src_x[31], i_src_x} - {i_target_x[31], i_target_x};
        w_d[1] = {i_src_y[31], i_src_y} - {i_target_y[31], i_target_y};
        w_d[2] = {i_src_z[31], i_src_z} - {i_target_z[31], i_target_z};
        for (int k = 0; k < 3; k++) begin
            w_term.neg[k] = w_d[k][32];
            // |d| never exceeds 2^32-1
            w_term.ax[k]  = w_d[k][32] ? ValW'(-w_d[k]) : ValW'(w_d[k]);
        end
        w_term.mass = i_src_mass;
        w_term.q    = {i_q_zz, i_q_yz, i_q_yy, i_q_xz, i_q_xy, i_q_xx};
        w_term.quad = i_is_cell & i_use_quad;
        w_term.last = i_last_term;
    end

    assign full         = (r_count == (QPtrW+1)'(QDepth));
    assign w_wr         = push & ~full;
    assign o_term_valid = (r_count != '0);
    assign o_term       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_term_take) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (QPtrW+1)'(w_wr) - (QPtrW+1)'(i_term_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wr_ptr] <= w_term;
    end

endmodule

// ===== design/sgacc_mul.sv =====
// ----------------------------------------------------------------------------
// sgacc_mul
// 64x64 multiplier, four 32x32 partial products, one per cycle.
// ----------------------------------------------------------------------------
module sgacc_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [63:0]                i_a,
    input  logic [63:0]                i_b,
    output logic                       o_done,
    output logic [sgacc_pkg::ProdW-1:0] o_p
);
    import sgacc_pkg::*;

    localparam logic [2:0] LastStep = 3'd4;

    logic             r_busy, r_done;
    logic [2:0]       r_step;
    logic [63:0]      r_a, r_b, r_pp;
    logic [1:0]       r_pp_sh;
    logic [ProdW-1:0] r_p, w_pp_ext;
    logic [31:0]      w_a_half, w_b_half;

    assign w_a_half = r_step[1] ? r_a[63:32] : r_a[31:0];
    assign w_b_half = r_step[0] ? r_b[63:32] : r_b[31:0];

    always_comb begin
        case (r_pp_sh)
            2'd0:    w_pp_ext = {64'b0, r_pp};
            2'd1:    w_pp_ext = {32'b0, r_pp, 32'b0};
            default: w_pp_ext = {r_pp, 64'b0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == LastStep) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial product registered, added in the following cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            if (r_step != LastStep) begin
                r_pp    <= w_a_half * w_b_half;
                r_pp_sh <= {1'b0, r_step[1]} + {1'b0, r_step[0]};
            end
            if (r_step != 3'd0) r_p <= r_p + w_pp_ext;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

// ===== design/sgacc_div.sv =====
// ----------------------------------------------------------------------------
// sgacc_div
// Radix-2 restoring divider, 128/64, quotient saturated to 63 bits.
// ----------------------------------------------------------------------------
module sgacc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sgacc_pkg::NumW-1:0]  i_num,
    input  logic [sgacc_pkg::DenW-1:0]  i_den,
    output logic                        o_done,
    output logic [sgacc_pkg::MagW-1:0]  o_q
);
    import sgacc_pkg::*;

    logic            r_busy, r_done;
    logic [5:0]      r_cnt;
    logic [DenW-1:0] r_rem, r_den, w_rem_nx;
    logic [MagW-1:0] r_low, r_q;
    logic [DenW:0]   w_hi, w_t;
    logic            w_sat, w_bit;

    // quotient >= 2^63 exactly when num >> 63 >= den
    assign w_hi  = i_num[NumW-1:MagW];
    assign w_sat = (w_hi >= {1'b0, i_den});

    assign w_t      = {r_rem, r_low[MagW-1]};
    assign w_bit    = (w_t >= {1'b0, r_den});
    assign w_rem_nx = w_bit ? DenW'(w_t - {1'b0, r_den}) : w_t[DenW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= ~w_sat;
                r_done <= w_sat;
                r_cnt  <= 6'(MagW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= w_sat ? MagMax : '0;
            r_rem <= w_hi[DenW-1:0];
            r_low <= i_num[MagW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_rem_nx;
            r_low <= {r_low[MagW-2:0], 1'b0};
            r_q   <= {r_q[MagW-2:0], w_bit};
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

// ===== design/sgacc_sqrt.sv =====
// ----------------------------------------------------------------------------
// sgacc_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module sgacc_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sgacc_pkg::RwW-1:0]    i_rad,
    output logic                         o_done,
    output logic [sgacc_pkg::RootW-1:0]  o_root
);
    import sgacc_pkg::*;

    localparam int RemW = RootW + 3;

    logic             r_busy, r_done;
    logic [5:0]       r_cnt;
    logic [RwW-1:0]   r_rad;
    logic [RemW-1:0]  r_rem, w_t, w_trial;
    logic [RootW-1:0] r_root;
    logic             w_ge;

    assign w_t     = {r_rem[RemW-3:0], r_rad[RwW-1:RwW-2]};
    assign w_trial = RemW'({r_root, 2'b01});
    assign w_ge    = (w_t >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(RootW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RwW-3:0], 2'b00};
            r_rem  <= w_ge ? (w_t - w_trial) : w_t;
            r_root <= {r_root[RootW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== design/sgacc_back.sv =====
// ----------------------------------------------------------------------------
// sgacc_back
// Term sequencer: shared multiplier, divider and root unit, saturating sums,
// result register.
// ----------------------------------------------------------------------------
module sgacc_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [31:0]          i_softening_sq,
    input  logic                 i_term_valid,
    input  sgacc_pkg::t_term     i_term,
    output logic                 o_term_take,
    output logic                 o_res_valid,
    output sgacc_pkg::t_result   o_res,
    input  logic                 i_res_pop
);
    import sgacc_pkg::*;

    typedef enum logic [16:0] {
        ST_IDLE   = 17'h00001,
        ST_SQ     = 17'h00002,
        ST_CHK    = 17'h00004,
        ST_ROOT   = 17'h00008,
        ST_PHI    = 17'h00010,
        ST_MONO_M = 17'h00020,
        ST_MONO_D = 17'h00040,
        ST_QD     = 17'h00080,
        ST_E      = 17'h00100,
        ST_G      = 17'h00200,
        ST_H      = 17'h00400,
        ST_PQ     = 17'h00800,
        ST_QPOT   = 17'h01000,
        ST_QC_M   = 17'h02000,
        ST_QC_D   = 17'h04000,
        ST_QH     = 17'h08000,
        ST_DONE   = 17'h10000
    } t_state;

    localparam logic [1:0] LastAxis = 2'd2;

    function automatic logic [2:0] q_index(input logic [1:0] k, input logic [1:0] j);
        logic [2:0] idx;
        unique case ({k, j})
            4'b00_00: idx = 3'd0;
            4'b00_01: idx = 3'd1;
            4'b00_10: idx = 3'd2;
            4'b01_00: idx = 3'd1;
            4'b01_01: idx = 3'd3;
            4'b01_10: idx = 3'd4;
            4'b10_00: idx = 3'd2;
            4'b10_01: idx = 3'd4;
            4'b10_10: idx = 3'd5;
            default:  idx = 3'd0;
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic signed [SumW-1:0] sat_add(input logic signed [SumW-1:0] a,
                                                       input logic neg,
                                                       input logic [MagW-1:0] mag);
        logic signed [SumW:0] m;
        logic signed [SumW:0] s;
        logic signed [SumW-1:0] r;
        m = signed'({2'b00, mag});
        s = {a[SumW-1], a} + (neg ? -m : m);
        if (s[SumW] != s[SumW-1]) r = s[SumW] ? {1'b1, {MagW{1'b0}}} : {1'b0, MagMax};
        else r = s[SumW-1:0];
        return r;
    endfunction

    t_state                 r_state, n_state;
    t_term                  r_term, n_term;
    logic [1:0]             r_k, n_k, r_j, n_j;
    logic [RwW-1:0]         r_rw, n_rw;
    logic [DenW-1:0]        r_r2, n_r2;
    logic [MagW-1:0]        r_phi, n_phi, r_c, n_c;
    logic [2:0][MagW-1:0]   r_h, n_h;
    logic [2:0]             r_hneg, n_hneg;
    logic                   r_pneg, n_pneg;
    logic signed [SumW-1:0] r_qd, n_qd, r_phq, n_phq, r_pot, n_pot;
    logic signed [SumW-1:0] r_acc [3];
    logic signed [SumW-1:0] n_acc [3];
    t_result                r_res, n_res;
    logic                   r_res_valid, n_res_valid;

    logic                   w_mul_start, w_mul_done;
    logic [63:0]            w_mul_a, w_mul_b;
    logic [ProdW-1:0]       w_mul_p;
    logic                   w_div_start, w_div_done;
    logic [NumW-1:0]        w_div_num;
    logic [DenW-1:0]        w_div_den;
    logic [MagW-1:0]        w_div_q;
    logic                   w_sqrt_start, w_sqrt_done;
    logic [RootW-1:0]       w_root;

    logic [2:0]             w_qi;
    logic                   w_qsgn;
    logic [SumW-1:0]        w_t, w_qm, w_pmag;
    logic signed [SumW-1:0] w_qd_nx;
    logic [ProdW-1:0]       w_pq_sh;
    logic [MagW-1:0]        w_pq_mag, w_pot_mag;
    logic [65:0]            w_c5;
    logic [MagW-1:0]        w_c;
    logic                   w_pop;

    sgacc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    sgacc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    sgacc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_rad   (r_rw),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // Q.d accumulation step
    assign w_qi    = q_index(r_k, r_j);
    assign w_qsgn  = r_term.q[w_qi][31] ^ r_term.neg[r_j];
    assign w_t     = SumW'(w_mul_p >> FRAC_BITS);
    assign w_qd_nx = w_qsgn ? (r_qd - signed'(w_t)) : (r_qd + signed'(w_t));
    assign w_qm    = w_qd_nx[SumW-1] ? SumW'(-w_qd_nx) : w_qd_nx;

    // quadrupole potential step: |d| h / 2^(F+1)
    assign w_pq_sh  = w_mul_p >> (FRAC_BITS + 1);
    assign w_pq_mag = (|w_pq_sh[ProdW-1:MagW]) ? MagMax : w_pq_sh[MagW-1:0];

    assign w_pmag    = r_phq[SumW-1] ? SumW'(-r_phq) : r_phq;
    assign w_pot_mag = w_pmag[SumW-1] ? MagMax : w_pmag[MagW-1:0];
    assign w_c5      = {2'b00, w_pmag} + {w_pmag, 2'b00};
    assign w_c       = (|w_c5[65:MagW]) ? MagMax : w_c5[MagW-1:0];

    assign w_pop = i_res_pop & r_res_valid;

    always_comb begin
        n_state     = r_state;
        n_term      = r_term;
        n_k         = r_k;
        n_j         = r_j;
        n_rw        = r_rw;
        n_r2        = r_r2;
        n_phi       = r_phi;
        n_c         = r_c;
        n_h         = r_h;
        n_hneg      = r_hneg;
        n_pneg      = r_pneg;
        n_qd        = r_qd;
        n_phq       = r_phq;
        n_pot       = r_pot;
        n_acc       = r_acc;
        n_res       = r_res;
        n_res_valid = r_res_valid & ~w_pop;
        o_term_take = 1'b0;
        w_mul_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        w_sqrt_start = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_term_valid) begin
                    o_term_take = 1'b1;
                    n_term      = i_term;
                    n_rw        = RwW'(i_softening_sq) << FRAC_BITS;
                    n_k         = '0;
                    w_mul_start = 1'b1;
                    w_mul_a     = 64'(i_term.ax[0]);
                    w_mul_b     = 64'(i_term.ax[0]);
                    n_state     = ST_SQ;
                end
            end
            ST_SQ: begin
                if (w_mul_done) begin
                    n_rw = r_rw + RwW'(w_mul_p);
                    if (r_k == LastAxis) begin
                        n_state = ST_CHK;
                    end else begin
                        n_k         = r_k + 2'd1;
                        w_mul_start = 1'b1;
                        w_mul_a     = 64'(r_term.ax[r_k + 2'd1]);
                        w_mul_b     = 64'(r_term.ax[r_k + 2'd1]);
                    end
                end
            end
            ST_CHK: begin
                n_r2 = DenW'(r_rw >> FRAC_BITS);
                // |d|^2 + softening below one Q16.16 LSB: no contribution
                if (n_r2 == '0) begin
                    n_state = ST_DONE;
                end else begin
                    w_sqrt_start = 1'b1;
                    n_state      = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (w_sqrt_done) begin
                    w_div_start = 1'b1;
                    w_div_num   = NumW'(r_term.mass) << (2 * FRAC_BITS);
                    w_div_den   = DenW'(w_root);
                    n_state     = ST_PHI;
                end
            end
            ST_PHI: begin
                if (w_div_done) begin
                    n_phi       = w_div_q;
                    n_pot       = sat_add(r_pot, 1'b1, w_div_q);
                    n_k         = '0;
                    w_mul_start = 1'b1;
                    w_mul_a     = 64'(r_term.ax[0]);
                    w_mul_b     = 64'(w_div_q);
                    n_state     = ST_MONO_M;
                end
            end
            ST_MONO_M: begin
                if (w_mul_done) begin
                    w_div_start = 1'b1;
                    w_div_num   = w_mul_p;
                    w_div_den   = r_r2;
                    n_state     = ST_MONO_D;
                end
            end
            ST_MONO_D: begin
                if (w_div_done) begin
                    n_acc[r_k] = sat_add(r_acc[r_k], r_term.neg[r_k], w_div_q);
                    if (r_k != LastAxis) begin
                        n_k         = r_k + 2'd1;
                        w_mul_start = 1'b1;
                        w_mul_a     = 64'(r_term.ax[r_k + 2'd1]);
                        w_mul_b     = 64'(r_phi);
                        n_state     = ST_MONO_M;
                    end else if (r_term.quad) begin
                        n_k         = '0;
                        n_j         = '0;
                        n_qd        = '0;
                        n_phq       = '0;
                        w_mul_start = 1'b1;
                        w_mul_a     = 64'(abs32(r_term.q[0]));
                        w_mul_b     = 64'(r_term.ax[0]);
                        n_state     = ST_QD;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_QD: begin
                if (w_mul_done) begin
                    n_qd = w_qd_nx;
                    if (r_j == LastAxis) begin
                        n_hneg[r_k] = w_qd_nx[SumW-1];
                        w_div_start = 1'b1;
                        w_div_num   = NumW'(w_qm) << (2 * FRAC_BITS);
                        w_div_den   = r_r2;
                        n_state     = ST_E;
                    end else begin
                        n_j         = r_j + 2'd1;
                        w_mul_start = 1'b1;
                        w_mul_a     = 64'(abs32(r_term.q[q_index(r_k, r_j + 2'd1)]));
                        w_mul_b     = 64'(r_term.ax[r_j + 2'd1]);
                    end
                end
            end
            ST_E: begin
                if (w_div_done) begin
                    w_div_start = 1'b1;
                    w_div_num   = NumW'(w_div_q) << FRAC_BITS;
                    w_div_den   = r_r2;
                    n_state     = ST_G;
                end
            end
            ST_G: begin
                if (w_div_done) begin
                    w_div_start = 1'b1;
                    w_div_num   = NumW'(w_div_q) << FRAC_BITS;
                    w_div_den   = DenW'(w_root);
                    n_state     = ST_H;
                end
            end
            ST_H: begin
                if (w_div_done) begin
                    n_h[r_k]    = w_div_q;
                    w_mul_start = 1'b1;
                    w_mul_a     = 64'(r_term.ax[r_k]);
                    w_mul_b     = 64'(w_div_q);
                    n_state     = ST_PQ;
                end
            end
            ST_PQ: begin
                if (w_mul_done) begin
                    n_phq = sat_add(r_phq, r_term.neg[r_k] ^ r_hneg[r_k], w_pq_mag);
                    if (r_k == LastAxis) begin
                        n_state = ST_QPOT;
                    end else begin
                        n_k         = r_k + 2'd1;
                        n_j         = '0;
                        n_qd        = '0;
                        w_mul_start = 1'b1;
                        w_mul_a     = 64'(abs32(r_term.q[q_index(r_k + 2'd1, 2'd0)]));
                        w_mul_b     = 64'(r_term.ax[0]);
                        n_state     = ST_QD;
                    end
                end
            end
            ST_QPOT: begin
                // potential gets -phi_q, then c = 5|phi_q|
                n_pot       = sat_add(r_pot, ~r_phq[SumW-1], w_pot_mag);
                n_pneg      = r_phq[SumW-1];
                n_c         = w_c;
                n_k         = '0;
                w_mul_start = 1'b1;
                w_mul_a     = 64'(r_term.ax[0]);
                w_mul_b     = 64'(w_c);
                n_state     = ST_QC_M;
            end
            ST_QC_M: begin
                if (w_mul_done) begin
                    w_div_start = 1'b1;
                    w_div_num   = w_mul_p;
                    w_div_den   = r_r2;
                    n_state     = ST_QC_D;
                end
            end
            ST_QC_D: begin
                if (w_div_done) begin
                    n_acc[r_k] = sat_add(r_acc[r_k], r_term.neg[r_k] ^ r_pneg, w_div_q);
                    n_state    = ST_QH;
                end
            end
            ST_QH: begin
                n_acc[r_k] = sat_add(r_acc[r_k], ~r_hneg[r_k], r_h[r_k]);
                if (r_k == LastAxis) begin
                    n_state = ST_DONE;
                end else begin
                    n_k         = r_k + 2'd1;
                    w_mul_start = 1'b1;
                    w_mul_a     = 64'(r_term.ax[r_k + 2'd1]);
                    w_mul_b     = 64'(r_c);
                    n_state     = ST_QC_M;
                end
            end
            ST_DONE: begin
                if (!r_term.last) begin
                    n_state = ST_IDLE;
                end else if (!r_res_valid || w_pop) begin
                    n_res.acc_x = r_acc[0];
                    n_res.acc_y = r_acc[1];
                    n_res.acc_z = r_acc[2];
                    n_res.pot   = r_pot;
                    n_res_valid = 1'b1;
                    n_acc[0]    = '0;
                    n_acc[1]    = '0;
                    n_acc[2]    = '0;
                    n_pot       = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
            r_pot       <= '0;
            r_acc[0]    <= '0;
            r_acc[1]    <= '0;
            r_acc[2]    <= '0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_pot       <= n_pot;
            r_acc       <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_term <= n_term;
        r_k    <= n_k;
        r_j    <= n_j;
        r_rw   <= n_rw;
        r_r2   <= n_r2;
        r_phi  <= n_phi;
        r_c    <= n_c;
        r_h    <= n_h;
        r_hneg <= n_hneg;
        r_pneg <= n_pneg;
        r_qd   <= n_qd;
        r_phq  <= n_phq;
        r_res  <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ===== design/softened_gravity_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// softened_gravity_accumulator_unit
// The shared divider dominates the time per term (4 divisions per body,
// 16 per cell), plus the multiplies and the root.
// Throughput: one term at a time in the back end; a 2-term queue in front.
// Reset (synchronous, active low) clears sums, queue and result; registers 0.
// ----------------------------------------------------------------------------
module softened_gravity_accumulator_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic signed [31:0]    i_src_x,
    input  logic signed [31:0]    i_src_y,
    input  logic signed [31:0]    i_src_z,
    input  logic [31:0]           i_src_mass,
    input  logic signed [31:0]    i_q_xx,
    input  logic signed [31:0]    i_q_xy,
    input  logic signed [31:0]    i_q_xz,
    input  logic signed [31:0]    i_q_yy,
    input  logic signed [31:0]    i_q_yz,
    input  logic signed [31:0]    i_q_zz,
    input  logic                  i_is_cell,
    input  logic                  i_last_term,
    output logic                  empty,
    input  logic                  pop,
    output logic signed [63:0]    o_acc_x,
    output logic signed [63:0]    o_acc_y,
    output logic signed [63:0]    o_acc_z,
    output logic signed [63:0]    o_potential
);
    import sgacc_pkg::*;

    logic signed [31:0] r_target_x, r_target_y, r_target_z;
    logic [31:0]        r_softening_sq;
    logic               r_use_quad;
    logic               w_term_valid, w_term_take, w_res_valid;
    t_term              w_term;
    t_result            w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x     <= '0;
            r_target_y     <= '0;
            r_target_z     <= '0;
            r_softening_sq <= '0;
            r_use_quad     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TARGET_X:  r_target_x     <= i_cfg_data;
                CFG_TARGET_Y:  r_target_y     <= i_cfg_data;
                CFG_TARGET_Z:  r_target_z     <= i_cfg_data;
                CFG_SOFTENING: r_softening_sq <= i_cfg_data;
                CFG_USE_QUAD:  r_use_quad     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    sgacc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_src_x      (i_src_x),
        .i_src_y      (i_src_y),
        .i_src_z      (i_src_z),
        .i_src_mass   (i_src_mass),
        .i_q_xx       (i_q_xx),
        .i_q_xy       (i_q_xy),
        .i_q_xz       (i_q_xz),
        .i_q_yy       (i_q_yy),
        .i_q_yz       (i_q_yz),
        .i_q_zz       (i_q_zz),
        .i_is_cell    (i_is_cell),
        .i_last_term  (i_last_term),
        .i_target_x   (r_target_x),
        .i_target_y   (r_target_y),
        .i_target_z   (r_target_z),
        .i_use_quad   (r_use_quad),
        .o_term_valid (w_term_valid),
        .o_term       (w_term),
        .i_term_take  (w_term_take)
    );

    sgacc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_softening_sq (r_softening_sq),
        .i_term_valid   (w_term_valid),
        .i_term         (w_term),
        .o_term_take    (w_term_take),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res),
        .i_res_pop      (pop)
    );

    assign empty       = ~w_res_valid;
    assign o_acc_x     = w_res.acc_x;
    assign o_acc_y     = w_res.acc_y;
    assign o_acc_z     = w_res.acc_z;
    assign o_potential = w_res.pot;

    a_take_needs_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_term_take |-> w_term_valid)
        else $error("back end took a term from an empty queue");

    a_full_has_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> w_term_valid)
        else $error("queue full but no term offered");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("reset left a word in a queue");

endmodule
